// ===== hw/rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants and types of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NumTasksDef = 16;
  localparam int NumPriosDef = 32;

  localparam int KindW  = 3;
  localparam int TaskW  = 4;
  localparam int PrioW  = 5;
  localparam int DelayW = 32;
  localparam int LockW  = 8;
  localparam int SliceW = 8;

  localparam logic [LockW-1:0]  LockMax    = 8'hFF;
  localparam logic [SliceW-1:0] SliceReset = 8'd10;

  typedef enum logic [KindW-1:0] {
    KIND_TICK     = 3'd0,
    KIND_MAKE     = 3'd1,
    KIND_REMOVE   = 3'd2,
    KIND_DELAY    = 3'd3,
    KIND_LOCK     = 3'd4,
    KIND_UNLOCK   = 3'd5,
    KIND_SCHEDULE = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_RM_T,
    ST_RM_P,
    ST_RM_CMP,
    ST_RM_WAIT,
    ST_TK_SCAN,
    ST_TK_DEC,
    ST_TK_T,
    ST_SL_START,
    ST_SL_T,
    ST_SL_P,
    ST_SL_H,
    ST_FIN,
    ST_FIN_W
  } state_e;

endpackage

// ===== hw/rtl/pts_if.sv =====
// ----------------------------------------------------------------------------
// pts_if
// Valid/ready channels of the priority task scheduler.
// ----------------------------------------------------------------------------
interface pts_req_if;
  import pts_pkg::*;
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [TaskW-1:0]  task_id;
  logic [PrioW-1:0]  priority_req;
  logic [DelayW-1:0] delay_ticks;
  modport source (output valid, kind, task_id, priority_req, delay_ticks, input ready);
  modport sink (input valid, kind, task_id, priority_req, delay_ticks, output ready);
endinterface

interface pts_rsp_if;
  import pts_pkg::*;
  logic             valid;
  logic             ready;
  logic             switch_now;
  logic [TaskW-1:0] next_task;
  logic             none_ready;
  logic [TaskW-1:0] current_task;
  logic [LockW-1:0] lock_level;
  modport source (output valid, switch_now, next_task, none_ready, current_task,
                  lock_level, input ready);
  modport sink (input valid, switch_now, next_task, none_ready, current_task,
                lock_level, output ready);
endinterface

interface pts_cfg_if;
  import pts_pkg::*;
  logic              valid;
  logic              ready;
  logic [SliceW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/pts_ram.sv =====
// ----------------------------------------------------------------------------
// pts_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Bitmap priority scheduler with one ordered ready queue per level and
// round robin among tasks of equal level.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one event beat (tick, make_ready, remove_ready, start_delay,
//   lock, unlock, schedule); rsp_o returns exactly one result beat per event.
//   cfg_i writes time_slice; write it only while the block is idle.
//   remove_ready walks the queue entries ahead of the task one by one.
//   A tick scans every task, decrements each delayed task's countdown and
//   pushes expiring tasks that are known and not yet ready, then does slice
//   rotation and a final lookup. The sequencer does one item at a time, as
//   each queue and task memory has one read port (read, modify, write back).
//   Reset clears the bitmap, the per-task flags, the lock count, the running
//   task and reloads the slice counter; no memory sweep is needed.
//   A finished result waits in the output register; the next event is
//   accepted meanwhile and only its final step holds while rsp_o stalls.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
  parameter int NUM_TASKS = pts_pkg::NumTasksDef,
  parameter int NUM_PRIOS = pts_pkg::NumPriosDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pts_req_if.sink     req_i,
  pts_rsp_if.source   rsp_o,
  pts_cfg_if.sink     cfg_i
);
  import pts_pkg::*;

  localparam int TW  = $clog2(NUM_TASKS);
  localparam int PW  = $clog2(NUM_PRIOS);
  localparam int CW  = $clog2(NUM_TASKS + 1);
  localparam int PEW = 2 * TW + CW;   // head, tail, count
  localparam int TEW = TW + PW;       // link, level

  // Control state
  state_e            state_q, state_d;
  logic [NUM_PRIOS-1:0] ready_q, ready_d;
  logic [NUM_TASKS-1:0] delayed_q, delayed_d;
  logic [NUM_TASKS-1:0] inrdy_q, inrdy_d;
  logic [NUM_TASKS-1:0] known_q, known_d;
  logic [SliceW-1:0] slice_q, slice_d;
  logic [SliceW-1:0] tslice_q;
  logic [TW-1:0]     run_q, run_d;
  logic [LockW-1:0]  lock_q, lock_d;
  logic              sched_q, sched_d;
  logic              tick_q, tick_d;
  logic              ovalid_q, ovalid_d;

  // Working registers
  logic [TW-1:0] t_q, t_d;
  logic [PW-1:0] lv_q, lv_d;
  logic [TW-1:0] idx_q, idx_d;
  logic [TW-1:0] cur_q, cur_d;
  logic [TW-1:0] prev_q, prev_d;
  logic [TW-1:0] link_q, link_d;
  logic [TW-1:0] head_q, head_d;
  logic [TW-1:0] tail_q, tail_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Output payload
  logic             osw_q, osw_d;
  logic [TaskW-1:0] onext_q, onext_d;
  logic             onone_q, onone_d;
  logic [TaskW-1:0] ocur_q, ocur_d;
  logic [LockW-1:0] olock_q, olock_d;

  // Memory ports
  logic           p_we, p_re;
  logic [PW-1:0]  p_waddr, p_raddr;
  logic [PEW-1:0] p_wdata, p_rdata;
  logic           t_we, t_re;
  logic [TW-1:0]  t_waddr, t_raddr;
  logic [TEW-1:0] t_wdata, t_rdata;
  logic           k_we, k_re;
  logic [TW-1:0]  k_waddr, k_raddr;
  logic [DelayW-1:0] k_wdata, k_rdata;

  // Per-level queue descriptor: head, tail, count
  pts_ram #(.Width(PEW), .Depth(NUM_PRIOS)) u_prio_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  // Per-task link and recorded level
  pts_ram #(.Width(TEW), .Depth(NUM_TASKS)) u_task_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(t_rdata)
  );
  // Per-task delay countdown
  pts_ram #(.Width(DelayW), .Depth(NUM_TASKS)) u_tick_ram (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .re_i(k_re), .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  logic [TW-1:0] p_head, p_tail, t_link;
  logic [CW-1:0] p_cnt;
  logic [PW-1:0] t_level;
  assign p_head  = p_rdata[PEW-1 -: TW];
  assign p_tail  = p_rdata[CW +: TW];
  assign p_cnt   = p_rdata[CW-1:0];
  assign t_link  = t_rdata[TEW-1 -: TW];
  assign t_level = t_rdata[PW-1:0];

  // Most urgent non-empty level
  logic [PW-1:0] top_lv;
  always_comb begin
    top_lv = '0;
    for (int k = NUM_PRIOS - 1; k >= 0; k--) begin
      if (ready_q[k]) begin
        top_lv = PW'(k);
      end
    end
  end

  // Request decode
  logic          acc;
  logic          tid_ok;
  logic [TW-1:0] req_t;
  logic [PW-1:0] req_lv;
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc    = req_i.valid && req_i.ready;
  assign tid_ok = 32'(req_i.task_id) < NUM_TASKS;
  assign req_t  = TW'(req_i.task_id);
  assign req_lv = (32'(req_i.priority_req) >= NUM_PRIOS) ? PW'(NUM_PRIOS - 1)
                                                          : PW'(req_i.priority_req);

  logic [CW-1:0]     eff_cnt;
  logic [DelayW-1:0] k_dec;
  logic [SliceW-1:0] slice_dec;
  logic              any_rdy;
  logic              last_idx;
  logic              sw;
  assign eff_cnt   = ready_q[lv_q] ? p_cnt : '0;
  assign k_dec     = k_rdata - DelayW'(1);
  assign slice_dec = slice_q - SliceW'(1);
  assign any_rdy   = |ready_q;
  assign last_idx  = (idx_q == TW'(NUM_TASKS - 1));

  always_comb begin
    state_d   = state_q;
    ready_d   = ready_q;
    delayed_d = delayed_q;
    inrdy_d   = inrdy_q;
    known_d   = known_q;
    slice_d   = slice_q;
    run_d     = run_q;
    lock_d    = lock_q;
    sched_d   = sched_q;
    tick_d    = tick_q;
    ovalid_d  = ovalid_q;
    t_d = t_q; lv_d = lv_q; idx_d = idx_q; cur_d = cur_q; prev_d = prev_q;
    link_d = link_q; head_d = head_q; tail_d = tail_q; i_d = i_q; cnt_d = cnt_q;
    osw_d = osw_q; onext_d = onext_q; onone_d = onone_q; ocur_d = ocur_q;
    olock_d = olock_q;
    p_we = 1'b0; p_re = 1'b0; p_waddr = lv_q; p_raddr = lv_q; p_wdata = '0;
    t_we = 1'b0; t_re = 1'b0; t_waddr = t_q; t_raddr = t_q; t_wdata = '0;
    k_we = 1'b0; k_re = 1'b0; k_waddr = idx_q; k_raddr = idx_q; k_wdata = '0;
    sw = 1'b0;

    // Drop the result once the sink takes it
    if (ovalid_q && rsp_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          sched_d = 1'b0;
          tick_d  = 1'b0;
          state_d = ST_FIN;
          case (kind_e'(req_i.kind))
            KIND_TICK: begin
              tick_d  = 1'b1;
              sched_d = 1'b1;
              idx_d   = '0;
              state_d = ST_TK_SCAN;
            end
            KIND_MAKE: begin
              if (tid_ok && !inrdy_q[req_t]) begin
                known_d[req_t] = 1'b1;
                t_d     = req_t;
                lv_d    = req_lv;
                p_re    = 1'b1;
                p_raddr = req_lv;
                state_d = ST_PUSH;
              end
            end
            KIND_REMOVE: begin
              if (tid_ok && inrdy_q[req_t]) begin
                t_d     = req_t;
                t_re    = 1'b1;
                t_raddr = req_t;
                state_d = ST_RM_T;
              end
            end
            KIND_DELAY: begin
              if (tid_ok) begin
                k_we    = 1'b1;
                k_waddr = req_t;
                k_wdata = req_i.delay_ticks;
                delayed_d[req_t] = 1'b1;
              end
            end
            KIND_LOCK: begin
              if (lock_q != LockMax) begin
                lock_d = lock_q + LockW'(1);
              end
            end
            KIND_UNLOCK: begin
              if (lock_q != '0) begin
                lock_d = lock_q - LockW'(1);
                if (lock_q == LockW'(1)) begin
                  sched_d = 1'b1;
                end
              end
            end
            KIND_SCHEDULE: begin
              sched_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // Link the task in at the head of its level
      ST_PUSH: begin
        t_we    = 1'b1;
        t_waddr = t_q;
        t_wdata = {p_head, lv_q};
        p_we    = 1'b1;
        p_waddr = lv_q;
        p_wdata = {t_q, (eff_cnt == '0) ? t_q : p_tail, eff_cnt + CW'(1)};
        ready_d[lv_q] = 1'b1;
        inrdy_d[t_q]  = 1'b1;
        if (!tick_q) begin
          state_d = ST_FIN;
        end else if (last_idx) begin
          state_d = ST_SL_START;
        end else begin
          idx_d   = idx_q + TW'(1);
          state_d = ST_TK_SCAN;
        end
      end

      ST_RM_T: begin
        lv_d    = t_level;
        link_d  = t_link;
        p_re    = 1'b1;
        p_raddr = t_level;
        state_d = ST_RM_P;
      end

      ST_RM_P: begin
        head_d  = p_head;
        tail_d  = p_tail;
        cnt_d   = eff_cnt;
        cur_d   = p_head;
        i_d     = '0;
        state_d = ST_RM_CMP;
      end

      // Walk the queue one link per visit until the task is found or the queue ends
      ST_RM_CMP: begin
        if (cnt_q == '0) begin
          inrdy_d[t_q] = 1'b0;
          state_d = ST_FIN;
        end else if (cur_q == t_q) begin
          if (i_q != '0) begin
            t_we    = 1'b1;
            t_waddr = prev_q;
            t_wdata = {link_q, lv_q};
          end
          p_we    = 1'b1;
          p_waddr = lv_q;
          p_wdata = {(i_q == '0) ? link_q : head_q,
                     ((CW'(i_q + CW'(1)) == cnt_q) && (i_q != '0)) ? prev_q : tail_q,
                     cnt_q - CW'(1)};
          if (cnt_q == CW'(1)) begin
            ready_d[lv_q] = 1'b0;
          end
          inrdy_d[t_q] = 1'b0;
          state_d = ST_FIN;
        end else if (CW'(i_q + CW'(1)) >= cnt_q) begin
          inrdy_d[t_q] = 1'b0;
          state_d = ST_FIN;
        end else begin
          prev_d  = cur_q;
          t_re    = 1'b1;
          t_raddr = cur_q;
          state_d = ST_RM_WAIT;
        end
      end

      ST_RM_WAIT: begin
        cur_d   = t_link;
        i_d     = i_q + CW'(1);
        state_d = ST_RM_CMP;
      end

      // Delay scan: one task per visit
      ST_TK_SCAN: begin
        if (delayed_q[idx_q]) begin
          k_re    = 1'b1;
          k_raddr = idx_q;
          state_d = ST_TK_DEC;
        end else if (last_idx) begin
          state_d = ST_SL_START;
        end else begin
          idx_d = idx_q + TW'(1);
        end
      end

      ST_TK_DEC: begin
        k_we    = 1'b1;
        k_waddr = idx_q;
        k_wdata = k_dec;
        if ((k_dec == '0) && !inrdy_q[idx_q] && known_q[idx_q]) begin
          delayed_d[idx_q] = 1'b0;
          t_d     = idx_q;
          t_re    = 1'b1;
          t_raddr = idx_q;
          state_d = ST_TK_T;
        end else begin
          if (k_dec == '0) begin
            delayed_d[idx_q] = 1'b0;
          end
          if (last_idx) begin
            state_d = ST_SL_START;
          end else begin
            idx_d   = idx_q + TW'(1);
            state_d = ST_TK_SCAN;
          end
        end
      end

      ST_TK_T: begin
        lv_d    = t_level;
        p_re    = 1'b1;
        p_raddr = t_level;
        state_d = ST_PUSH;
      end

      // Slice countdown and round-robin rotation
      ST_SL_START: begin
        slice_d = slice_dec;
        state_d = ST_FIN;
        if (slice_dec == '0) begin
          slice_d = tslice_q;
          if ((32'(run_q) < NUM_TASKS) && known_q[run_q]) begin
            t_re    = 1'b1;
            t_raddr = run_q;
            state_d = ST_SL_T;
          end
        end
      end

      ST_SL_T: begin
        lv_d    = t_level;
        p_re    = 1'b1;
        p_raddr = t_level;
        state_d = ST_SL_P;
      end

      ST_SL_P: begin
        state_d = ST_FIN;
        if (eff_cnt >= CW'(2)) begin
          head_d  = p_head;
          tail_d  = p_tail;
          cnt_d   = p_cnt;
          t_re    = 1'b1;
          t_raddr = p_head;
          state_d = ST_SL_H;
        end
      end

      ST_SL_H: begin
        p_we    = 1'b1;
        p_waddr = lv_q;
        p_wdata = {t_link, head_q, cnt_q};
        t_we    = 1'b1;
        t_waddr = tail_q;
        t_wdata = {head_q, lv_q};
        state_d = ST_FIN;
      end

      ST_FIN: begin
        p_re    = 1'b1;
        p_raddr = top_lv;
        state_d = ST_FIN_W;
      end

      // Schedule and report; hold while the previous result is still waiting
      ST_FIN_W: begin
        if (!ovalid_q || rsp_o.ready) begin
          sw = sched_q && (lock_q == '0) && any_rdy && (p_head != run_q);
          if (sw) begin
            run_d = p_head;
          end
          osw_d    = sw;
          onext_d  = any_rdy ? TaskW'(p_head) : '0;
          onone_d  = !any_rdy;
          ocur_d   = TaskW'(sw ? p_head : run_q);
          olock_d  = lock_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ready_q   <= '0;
      delayed_q <= '0;
      inrdy_q   <= '0;
      known_q   <= '0;
      slice_q   <= SliceReset;
      tslice_q  <= SliceReset;
      run_q     <= '0;
      lock_q    <= '0;
      sched_q   <= 1'b0;
      tick_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ready_q   <= ready_d;
      delayed_q <= delayed_d;
      inrdy_q   <= inrdy_d;
      known_q   <= known_d;
      slice_q   <= slice_d;
      run_q     <= run_d;
      lock_q    <= lock_d;
      sched_q   <= sched_d;
      tick_q    <= tick_d;
      ovalid_q  <= ovalid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        tslice_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    lv_q   <= lv_d;
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    link_q <= link_d;
    head_q <= head_d;
    tail_q <= tail_d;
    i_q    <= i_d;
    cnt_q  <= cnt_d;
    osw_q  <= osw_d;
    onext_q <= onext_d;
    onone_q <= onone_d;
    ocur_q  <= ocur_d;
    olock_q <= olock_d;
  end

  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.switch_now   = osw_q;
  assign rsp_o.next_task    = onext_q;
  assign rsp_o.none_ready   = onone_q;
  assign rsp_o.current_task = ocur_q;
  assign rsp_o.lock_level   = olock_q;
endmodule
